/* rtl/mdfc_pkg.sv */
// Package for the dock link frame codec: item types, field widths and codes.
// No dependencies; used by every other file of the block.
package mdfc_pkg;

  // Field widths
  localparam int unsigned RegIdW    = 3;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned RespLineW = 20;
  localparam int unsigned LineW     = 32;
  localparam int unsigned CountW    = 6;
  localparam int unsigned WordW     = 16;

  // Action codes
  localparam logic ACT_ENCODE = 1'b0;
  localparam logic ACT_CHECK  = 1'b1;

  // Status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // Line bit counts of the two command lengths
  localparam logic [CountW-1:0] LINE_CNT_WR   = 6'd32;
  localparam logic [CountW-1:0] LINE_CNT_RD   = 6'd16;
  localparam logic [CountW-1:0] LINE_CNT_NONE = 6'd0;

  typedef struct packed {
    logic                 action;
    logic [RegIdW-1:0]    reg_id;
    logic                 is_write;
    logic [ByteW-1:0]     write_data;
    logic [RespLineW-1:0] resp_line_bits;
    logic                 resp_timing_error;
  } in_item_t;

  typedef struct packed {
    logic [LineW-1:0]  line_bits;
    logic [CountW-1:0] line_bit_count;
    logic [ByteW-1:0]  resp_data;
    logic              status;
  } out_item_t;

endpackage

/* rtl/mdfc_if.sv */
// Valid/ready channel interfaces for the dock link frame codec.
// Depends on mdfc_pkg for field widths.
interface mdfc_in_if;
  logic                           valid;
  logic                           ready;
  logic                           action;
  logic [mdfc_pkg::RegIdW-1:0]    reg_id;
  logic                           is_write;
  logic [mdfc_pkg::ByteW-1:0]     write_data;
  logic [mdfc_pkg::RespLineW-1:0] resp_line_bits;
  logic                           resp_timing_error;

  modport source (
    output valid, action, reg_id, is_write, write_data, resp_line_bits,
           resp_timing_error,
    input  ready
  );
  modport sink (
    input  valid, action, reg_id, is_write, write_data, resp_line_bits,
           resp_timing_error,
    output ready
  );
endinterface

interface mdfc_out_if;
  logic                        valid;
  logic                        ready;
  logic [mdfc_pkg::LineW-1:0]  line_bits;
  logic [mdfc_pkg::CountW-1:0] line_bit_count;
  logic [mdfc_pkg::ByteW-1:0]  resp_data;
  logic                        status;

  modport source (
    output valid, line_bits, line_bit_count, resp_data, status,
    input  ready
  );
  modport sink (
    input  valid, line_bits, line_bit_count, resp_data, status,
    output ready
  );
endinterface

/* rtl/mdfc_core.sv */
// Combinational frame logic: MFM encode of a command, decode and check of a response.
// Depends on mdfc_pkg.
module mdfc_core (
  input  mdfc_pkg::in_item_t  item,
  output mdfc_pkg::out_item_t res
);
  import mdfc_pkg::*;

  // MFM encode of a 16-bit word: data k at line 2k+1, clock k at line 2k.
  // Clock bit is set when neither bit k nor bit k-1 is one.
  function automatic logic [LineW-1:0] mfm_enc(input logic [WordW-1:0] word,
                                               input logic below);
    logic [LineW-1:0] line;
    logic             prev;
    line = '0;
    for (int k = 0; k < WordW; k++) begin
      prev = (k == 0) ? below : word[(k == 0) ? 0 : k-1];
      line[2*k+1] = word[k];
      line[2*k]   = ~word[k] & ~prev;
    end
    return line;
  endfunction

  logic [WordW-1:0] cmd_word;
  logic [LineW-1:0] cmd_line;
  logic [9:0]       rsp_data;
  logic [LineW-1:0] rsp_line;
  logic             rsp_match;
  logic             rsp_stop;
  logic             rsp_ok;

  // Command word assembly
  always_comb begin
    cmd_word        = '0;
    cmd_word[1:0]   = 2'b11;
    cmd_word[2]     = item.is_write;
    cmd_word[5:3]   = item.reg_id;
    if (item.is_write) begin
      cmd_word[13:6] = item.write_data;
      cmd_word[14]   = 1'b1;
    end else begin
      cmd_word[6]    = 1'b1;
    end
  end

  assign cmd_line = mfm_enc(cmd_word, 1'b0);

  // Response: pick data bits off the odd line positions
  always_comb begin
    for (int k = 0; k < 10; k++) begin
      rsp_data[k] = item.resp_line_bits[2*k+1];
    end
  end

  // Re-encode with a one below bit 0; only the used line bits are compared
  assign rsp_line  = mfm_enc({6'd0, rsp_data}, 1'b1);
  assign rsp_match = item.is_write ? (rsp_line[5:0] == item.resp_line_bits[5:0])
                                   : (rsp_line[19:0] == item.resp_line_bits);
  assign rsp_stop  = item.is_write ? rsp_data[1] : rsp_data[8];
  assign rsp_ok    = rsp_match & rsp_stop & ~item.resp_timing_error;

  // Result selection
  always_comb begin
    res = '0;
    if (item.action == ACT_ENCODE) begin
      if (item.is_write) begin
        res.line_bits      = cmd_line;
        res.line_bit_count = LINE_CNT_WR;
      end else begin
        res.line_bits      = {16'd0, cmd_line[15:0]};
        res.line_bit_count = LINE_CNT_RD;
      end
      res.status = STATUS_OK;
    end else if (rsp_ok) begin
      res.line_bit_count = LINE_CNT_NONE;
      res.resp_data      = item.is_write ? {7'd0, rsp_data[0]} : rsp_data[7:0];
      res.status         = STATUS_OK;
    end else begin
      res.status         = STATUS_BAD;
    end
  end

endmodule

/* rtl/mfm_dock_frame_codec.sv */
// Top level of the dock link frame codec: input register, frame logic, result register.
// Depends on mdfc_pkg, mdfc_if and mdfc_core.
//
// Each transfer on in_ch either MFM-encodes a command frame (action 0) or
// decodes and checks a received response (action 1), giving exactly one
// transfer on out_ch. The block holds no state between items. An item is
// held in the input register while the encode/check logic works on it and then
// sits in the result register, from which its result is offered on out_ch. One
// item can be taken every cycle while out_ch is not stalled; the rate is set by
// the single register-to-register pass through the encode/check logic. A stall
// on out_ch fills both registers and then drops in_ch.ready combinationally.
module mfm_dock_frame_codec (
  input  logic         clk,
  input  logic         rst_n,
  mdfc_in_if.sink      in_ch,
  mdfc_out_if.source   out_ch
);
  import mdfc_pkg::*;

  in_item_t  in_item;
  in_item_t  s1_item_r;
  logic      s1_valid_r;
  logic      s1_valid_nxt;
  out_item_t core_res;
  out_item_t s2_item_r;
  logic      s2_valid_r;
  logic      s2_valid_nxt;
  logic      s1_adv;
  logic      in_xfer;

  // Gather the input payload
  assign in_item.action            = in_ch.action;
  assign in_item.reg_id            = in_ch.reg_id;
  assign in_item.is_write          = in_ch.is_write;
  assign in_item.write_data        = in_ch.write_data;
  assign in_item.resp_line_bits    = in_ch.resp_line_bits;
  assign in_item.resp_timing_error = in_ch.resp_timing_error;

  // Pipeline flow control
  assign s1_adv       = ~s2_valid_r | out_ch.ready;
  assign in_ch.ready  = ~s1_valid_r | s1_adv;
  assign in_xfer      = in_ch.valid & in_ch.ready;
  assign s1_valid_nxt = in_xfer | (s1_valid_r & ~s1_adv);
  assign s2_valid_nxt = (s1_valid_r & s1_adv) | (s2_valid_r & ~out_ch.ready);

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= in_item;
    end
    if (s1_valid_r && s1_adv) begin
      s2_item_r <= core_res;
    end
  end

  mdfc_core u_core (
    .item (s1_item_r),
    .res  (core_res)
  );

  // Result channel
  assign out_ch.valid          = s2_valid_r;
  assign out_ch.line_bits      = s2_item_r.line_bits;
  assign out_ch.line_bit_count = s2_item_r.line_bit_count;
  assign out_ch.resp_data      = s2_item_r.resp_data;
  assign out_ch.status         = s2_item_r.status;

  // A command result never carries response data or a bad status
  a_enc_clean: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && s2_item_r.line_bit_count != LINE_CNT_NONE |->
      s2_item_r.status == STATUS_OK && s2_item_r.resp_data == '0)
    else $error("command result with response fields set");

  // A bad response returns no data and no line bits
  a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && s2_item_r.status == STATUS_BAD |->
      s2_item_r.resp_data == '0 && s2_item_r.line_bits == '0)
    else $error("bad response with payload");

  // Line bit count is one of the three legal values
  a_cnt_legal: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> s2_item_r.line_bit_count == LINE_CNT_WR ||
                   s2_item_r.line_bit_count == LINE_CNT_RD ||
                   s2_item_r.line_bit_count == LINE_CNT_NONE)
    else $error("illegal line bit count");

  // Both stages full and stalled: no new transfer may be taken
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s2_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while pipeline is full");

  // A held result stays in the result register
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && !out_ch.ready |=> s2_valid_r && $stable(s2_item_r))
    else $error("stalled result lost");

endmodule

/* test/tb_mfm_dock_frame_codec.sv */
`timescale 1ns / 100ps
// Testbench for the dock link frame codec: random and directed command and response frames.
// Depends on mdfc_pkg, mdfc_if and the RTL top level mfm_dock_frame_codec.
module tb_mfm_dock_frame_codec;
  import mdfc_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned RANDOM_FRAMES = 600;
  localparam int unsigned HOLD_CYCLES   = 100;

  logic clk;
  logic rst_n;

  mdfc_in_if  in_ch();
  mdfc_out_if out_ch();

  mfm_dock_frame_codec dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  in_item_t    frames_to_send[$];
  out_item_t   results_due[$];
  in_item_t    frame_on_bus;
  out_item_t   due_res;
  int unsigned frames_queued;
  int unsigned frames_taken;
  int unsigned mismatches = 0;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned hold_cnt;
  logic        hold_done;
  logic [15:0] stall_pat;
  int unsigned pat_age;
  int unsigned cycle_cnt;

  // MFM line image of a word: data bit k at line bit 2k+1, clock bit at 2k
  function automatic logic [31:0] mfm_wrap(logic [15:0] word, int unsigned nbits,
                                           logic below);
    logic [31:0] line;
    logic        prev;
    int unsigned k;
    line = '0;
    prev = below;
    for (k = 0; k < nbits; k++) begin
      line[2*k+1] = word[k];
      line[2*k]   = ~word[k] & ~prev;
      prev        = word[k];
    end
    return line;
  endfunction

  // Expected result of one frame
  function automatic out_item_t predict_frame(in_item_t it);
    out_item_t   r;
    logic [15:0] word;
    logic [19:0] used;
    logic [19:0] mask;
    logic [9:0]  data;
    logic [31:0] reenc;
    int unsigned rbits;
    int unsigned k;
    r    = '0;
    word = '0;
    data = '0;
    r.status = STATUS_OK;
    if (it.action == ACT_ENCODE) begin
      word[1:0] = 2'b11;
      word[2]   = it.is_write;
      word[5:3] = it.reg_id;
      if (it.is_write) begin
        word[13:6]       = it.write_data;
        word[14]         = 1'b1;
        r.line_bits      = mfm_wrap(word, 16, 1'b0);
        r.line_bit_count = LINE_CNT_WR;
      end else begin
        word[6]          = 1'b1;
        r.line_bits      = mfm_wrap(word, 8, 1'b0);
        r.line_bit_count = LINE_CNT_RD;
      end
    end else begin
      rbits = it.is_write ? 3 : 10;
      mask  = 20'((32'h1 << (2 * rbits)) - 1);
      used  = it.resp_line_bits & mask;
      for (k = 0; k < rbits; k++)
        data[k] = used[2*k+1];
      reenc = mfm_wrap({6'b0, data}, rbits, 1'b1);
      r.line_bit_count = LINE_CNT_NONE;
      if (reenc[19:0] == used && !it.resp_timing_error && data[rbits-2]) begin
        r.resp_data = data[7:0] & 8'((32'h1 << (rbits - 2)) - 1);
      end else begin
        r.status = STATUS_BAD;
      end
    end
    return r;
  endfunction

  // Well-formed response line bits; spare is the bit above the stop bit
  function automatic logic [19:0] good_response(logic wr, logic [7:0] data, logic spare);
    logic [31:0] line;
    if (wr)
      line = mfm_wrap({13'b0, spare, 1'b1, data[0]}, 3, 1'b1);
    else
      line = mfm_wrap({6'b0, spare, 1'b1, data}, 10, 1'b1);
    return line[19:0];
  endfunction

  task automatic queue_command(logic [2:0] rid, logic wr, logic [7:0] data);
    in_item_t it;
    it.action            = ACT_ENCODE;
    it.reg_id            = rid;
    it.is_write          = wr;
    it.write_data        = data;
    it.resp_line_bits    = 20'($urandom);
    it.resp_timing_error = 1'($urandom);
    frames_to_send.push_back(it);
    frames_queued++;
  endtask

  task automatic queue_response(logic wr, logic [19:0] line, logic terr);
    in_item_t it;
    it.action            = ACT_CHECK;
    it.reg_id            = 3'($urandom);
    it.is_write          = wr;
    it.write_data        = 8'($urandom);
    it.resp_line_bits    = line;
    it.resp_timing_error = terr;
    frames_to_send.push_back(it);
    frames_queued++;
  endtask

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0h, got %0h", what, want, got);
  endtask

  // Sender holds off until everything sent so far has come back
  task automatic drain_all();
    while (frames_taken != frames_queued || results_due.size() != 0)
      @(negedge clk);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reset and stimulus
  initial begin
    logic        wr;
    logic [7:0]  data;
    logic [19:0] line;
    int unsigned pick;
    int unsigned i;
    rst_n         = 1'b0;
    frames_queued = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: command extremes, ignored data byte on reads
    queue_command(3'd0, 1'b0, 8'h00);
    queue_command(3'd7, 1'b0, 8'hFF);
    queue_command(3'd0, 1'b1, 8'h00);
    queue_command(3'd7, 1'b1, 8'hFF);
    queue_command(3'd5, 1'b1, 8'hA5);
    queue_command(3'd2, 1'b1, 8'h5A);
    // Well-formed responses, both lengths
    queue_response(1'b0, good_response(1'b0, 8'h00, 1'b0), 1'b0);
    queue_response(1'b0, good_response(1'b0, 8'hFF, 1'b0), 1'b0);
    queue_response(1'b0, good_response(1'b0, 8'h3C, 1'b1), 1'b0);
    queue_response(1'b1, good_response(1'b1, 8'h00, 1'b0), 1'b0);
    queue_response(1'b1, good_response(1'b1, 8'h01, 1'b1), 1'b0);
    // Write response with the unused upper line bits all set
    queue_response(1'b1, good_response(1'b1, 8'h01, 1'b0) | 20'hFFFC0, 1'b0);
    // Timing error on otherwise good responses
    queue_response(1'b0, good_response(1'b0, 8'h81, 1'b0), 1'b1);
    queue_response(1'b1, good_response(1'b1, 8'h00, 1'b0), 1'b1);
    // Stop bit clear but clock bits consistent
    line = 20'(mfm_wrap(16'h0055, 10, 1'b1));
    queue_response(1'b0, line[19:0], 1'b0);
    line = 20'(mfm_wrap(16'h0001, 3, 1'b1));
    queue_response(1'b1, line[19:0], 1'b0);
    // Clock bit mismatches
    queue_response(1'b0, good_response(1'b0, 8'h42, 1'b0) ^ 20'h00001, 1'b0);
    queue_response(1'b1, good_response(1'b1, 8'h01, 1'b0) ^ 20'h00010, 1'b0);
    // Line extremes
    queue_response(1'b0, 20'h00000, 1'b0);
    queue_response(1'b0, 20'hFFFFF, 1'b0);
    queue_response(1'b1, 20'h00000, 1'b0);
    queue_response(1'b1, 20'h0003F, 1'b0);
    drain_all();

    // Random frames, mostly well-formed responses and commands
    for (i = 0; i < RANDOM_FRAMES; i++) begin
      if (i == RANDOM_FRAMES / 2)
        drain_all();
      pick = $urandom_range(0, 99);
      wr   = 1'($urandom);
      data = 8'($urandom);
      if (pick < 35) begin
        queue_command(3'($urandom), wr, data);
      end else if (pick < 88) begin
        line = good_response(wr, data, 1'($urandom));
        if (wr)
          line = line | (20'($urandom) & 20'hFFFC0);
        // occasional single flipped line bit
        if (pick >= 75)
          line = line ^ (20'h1 << $urandom_range(0, wr ? 5 : 19));
        queue_response(wr, line, $urandom_range(0, 9) == 0);
      end else begin
        queue_response(wr, 20'($urandom), 1'($urandom));
      end
    end

    drain_all();
    repeat (10) @(posedge clk);
    if (results_due.size() != 0)
      note_mismatch("results outstanding at end", 32'd0, 32'(results_due.size()));
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Driver: bursts of transfers with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid             <= 1'b0;
      in_ch.action            <= ACT_ENCODE;
      in_ch.reg_id            <= '0;
      in_ch.is_write          <= 1'b0;
      in_ch.write_data        <= '0;
      in_ch.resp_line_bits    <= '0;
      in_ch.resp_timing_error <= 1'b0;
      frames_taken            <= 0;
      burst_left              = $urandom_range(1, 20);
      gap_left                = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        results_due.push_back(predict_frame(frame_on_bus));
        frames_taken <= frames_taken + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (frames_to_send.size() != 0) begin
          frame_on_bus = frames_to_send.pop_front();
          in_ch.valid             <= 1'b1;
          in_ch.action            <= frame_on_bus.action;
          in_ch.reg_id            <= frame_on_bus.reg_id;
          in_ch.is_write          <= frame_on_bus.is_write;
          in_ch.write_data        <= frame_on_bus.write_data;
          in_ch.resp_line_bits    <= frame_on_bus.resp_line_bits;
          in_ch.resp_timing_error <= frame_on_bus.resp_timing_error;
          burst_left--;
          if (burst_left == 0) begin
            // some long bursts with no gap at all
            if ($urandom_range(0, 3) == 0) begin
              burst_left = 40;
              gap_left   = 0;
            end else begin
              burst_left = $urandom_range(1, 20);
              gap_left   = $urandom_range(1, 12);
            end
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, once, while frames keep coming
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && frames_taken >= 150) begin
      hold_cnt  <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // Receiver: rotating stall pattern, re-chosen at random each time pat_age wraps
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_pat    = 16'hFFFF;
      pat_age      = 0;
    end else begin
      pat_age++;
      if (pat_age == 48) begin
        pat_age = 0;
        case ($urandom_range(0, 3))
          0: begin
            stall_pat = 16'hFFFF;
          end
          1: begin
            stall_pat = 16'($urandom);
          end
          2: begin
            stall_pat = 16'($urandom) & 16'($urandom);
          end
          default: begin
            stall_pat = 16'($urandom) | 16'($urandom);
          end
        endcase
      end
      stall_pat    = {stall_pat[0], stall_pat[15:1]};
      out_ch.ready <= (hold_cnt == 0) && stall_pat[0];
    end
  end

  // Monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (results_due.size() == 0) begin
        note_mismatch("result with nothing outstanding", 32'd0, 32'd1);
      end else begin
        due_res = results_due.pop_front();
        if (out_ch.line_bits !== due_res.line_bits)
          note_mismatch("line_bits", due_res.line_bits, out_ch.line_bits);
        if (out_ch.line_bit_count !== due_res.line_bit_count)
          note_mismatch("line_bit_count", 32'(due_res.line_bit_count),
                        32'(out_ch.line_bit_count));
        if (out_ch.resp_data !== due_res.resp_data)
          note_mismatch("resp_data", 32'(due_res.resp_data), 32'(out_ch.resp_data));
        if (out_ch.status !== due_res.status)
          note_mismatch("status", 32'(due_res.status), 32'(out_ch.status));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      cycle_cnt <= 0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule
